@@ hdl/go_to_goal_heading_controller_top_assert.svh @@
// assertion macros used by the top-level rtl file
// both expect clk and arst_n in the scope where they are used
`ifndef GO_TO_GOAL_HEADING_CONTROLLER_TOP_ASSERT_SVH
`define GO_TO_GOAL_HEADING_CONTROLLER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define GTG_CHECK(lbl, ant, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (cons)) \
		else $error("gtg check failed");

// next-cycle implication
`define GTG_CHECK_NEXT(lbl, ant, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (cons)) \
		else $error("gtg next-cycle check failed");

`else

`define GTG_CHECK(lbl, ant, cons)
`define GTG_CHECK_NEXT(lbl, ant, cons)

`endif

`endif

@@ hdl/gtg_pkg.sv @@
package gtg_pkg;

	// number format and iteration count
	localparam int FRAC_BITS    = 12;
	localparam int CORDIC_STEPS = 16;

	// field widths
	localparam int POS_W    = 16;
	localparam int ANG_W    = 16;
	localparam int THR_W    = 24;
	localparam int SPEED_W  = 16;
	localparam int GAIN_W   = 4;
	localparam int DBAND_W  = 12;
	localparam int RATE_W   = 18;

	// internal widths
	localparam int DIFF_W   = POS_W + 1;
	localparam int DSQ_W    = 2 * POS_W + 1;
	localparam int SQ_CNT_W = $clog2(POS_W);
	localparam int SCALE_SH = 16;
	localparam int CX_W     = 36;
	localparam int CX_PAD   = CX_W - DIFF_W - SCALE_SH;
	localparam int CZ_W     = 34;
	localparam int ERR_W    = ANG_W + 1;
	localparam int PROD_W   = ERR_W + GAIN_W;
	localparam int ST_CNT_W = $clog2(GAIN_W + 2);

	// arctangent table
	localparam int ATAN_LEN   = 24;
	localparam int ATAN_IDX_W = $clog2(ATAN_LEN + 1);
	localparam int ATAN_W     = 31;

	// angle constants
	localparam int     ANG_FRAC  = 30;
	localparam int     RND_SH    = ANG_FRAC - FRAC_BITS;
	localparam longint PI_Q30    = 64'sd3373259426;
	localparam longint RND_HALF  = longint'(1) << (RND_SH - 1);
	localparam longint PI_F      = (PI_Q30 + RND_HALF) >>> RND_SH;
	localparam longint TWO_PI_F  = (2 * PI_Q30 + RND_HALF) >>> RND_SH;
	localparam longint WRAP_LIM  = PI_F + ((longint'(1) << FRAC_BITS) + 50) / 100;

	localparam int RATE_MAX = (1 << (RATE_W - 1)) - 1;
	localparam int RATE_MIN = -(1 << (RATE_W - 1));

	// configuration port, index wide enough to address past the last register
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = THR_W;

	localparam logic REQ_OWN = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ARRIVE,
		CFG_SPEED,
		CFG_GAIN,
		CFG_DEADBAND
	} cfg_idx_t;

	typedef struct packed {
		logic [THR_W-1:0]   arrive_thr;
		logic [SPEED_W-1:0] fwd_speed;
		logic [GAIN_W-1:0]  gain;
		logic [DBAND_W-1:0] deadband;
	} cfg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_TURN,
		ST_SEND
	} state_t;

	// atan(2^-i) in q.30
	function automatic logic [ATAN_W-1:0] atan_q30(input logic [ATAN_IDX_W-1:0] idx);
		logic [ATAN_W-1:0] v;
		case (idx)
			5'd0:    v = 31'd843314856;
			5'd1:    v = 31'd497837829;
			5'd2:    v = 31'd263043836;
			5'd3:    v = 31'd133525158;
			5'd4:    v = 31'd67021686;
			5'd5:    v = 31'd33543515;
			5'd6:    v = 31'd16775850;
			5'd7:    v = 31'd8388437;
			5'd8:    v = 31'd4194282;
			5'd9:    v = 31'd2097149;
			5'd10:   v = 31'd1048575;
			5'd11:   v = 31'd524287;
			5'd12:   v = 31'd262143;
			5'd13:   v = 31'd131071;
			5'd14:   v = 31'd65535;
			5'd15:   v = 31'd32767;
			5'd16:   v = 31'd16383;
			5'd17:   v = 31'd8191;
			5'd18:   v = 31'd4095;
			5'd19:   v = 31'd2047;
			5'd20:   v = 31'd1023;
			5'd21:   v = 31'd511;
			5'd22:   v = 31'd255;
			5'd23:   v = 31'd127;
			default: v = '0;
		endcase
		return v;
	endfunction

	// magnitude of a signed position difference
	function automatic logic [POS_W-1:0] abs_diff(input logic signed [DIFF_W-1:0] d);
		logic [DIFF_W-1:0] n;
		n = -d;
		return d[DIFF_W-1] ? n[POS_W-1:0] : d[POS_W-1:0];
	endfunction

endpackage

@@ hdl/gtg_if.sv @@
// pose update channel
interface gtg_pose_if;
	logic                                 valid;
	logic                                 ready;
	logic                                 req_type;
	logic [gtg_pkg::POS_W-1:0]            pos_x;
	logic [gtg_pkg::POS_W-1:0]            pos_y;
	logic signed [gtg_pkg::ANG_W-1:0]     heading;

	modport source (output valid, output req_type, output pos_x, output pos_y,
		output heading, input ready);
	modport sink (input valid, input req_type, input pos_x, input pos_y,
		input heading, output ready);
endinterface

// drive command channel
interface gtg_cmd_if;
	logic                                 valid;
	logic                                 ready;
	logic [gtg_pkg::SPEED_W-1:0]          linear_speed;
	logic signed [gtg_pkg::RATE_W-1:0]    angular_rate;
	logic                                 reached;

	modport source (output valid, output linear_speed, output angular_rate,
		output reached, input ready);
	modport sink (input valid, input linear_speed, input angular_rate,
		input reached, output ready);
endinterface

@@ hdl/gtg_sqdist.sv @@
module gtg_sqdist (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic signed [gtg_pkg::DIFF_W-1:0]  dx,
	input  logic signed [gtg_pkg::DIFF_W-1:0]  dy,
	output logic                               busy,
	output logic [gtg_pkg::DSQ_W-1:0]          dsq
);

	logic [gtg_pkg::POS_W-1:0]    mx_q, my_q, sx_q, sy_q;
	logic [gtg_pkg::DSQ_W-1:0]    acc_q, acc_d;
	logic [gtg_pkg::SQ_CNT_W-1:0] cnt_q;
	logic                         busy_q;

	// msb first: shift the sum left and add both partial products for one bit
	always_comb begin
		acc_d = (acc_q << 1)
			+ (sx_q[gtg_pkg::POS_W-1] ? gtg_pkg::DSQ_W'(mx_q) : '0)
			+ (sy_q[gtg_pkg::POS_W-1] ? gtg_pkg::DSQ_W'(my_q) : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == gtg_pkg::SQ_CNT_W'(gtg_pkg::POS_W - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mx_q  <= gtg_pkg::abs_diff(dx);
			sx_q  <= gtg_pkg::abs_diff(dx);
			my_q  <= gtg_pkg::abs_diff(dy);
			sy_q  <= gtg_pkg::abs_diff(dy);
			acc_q <= '0;
		end else if (busy_q) begin
			sx_q  <= sx_q << 1;
			sy_q  <= sy_q << 1;
			acc_q <= acc_d;
		end
	end

	assign busy = busy_q;
	assign dsq  = acc_q;

endmodule

@@ hdl/gtg_cordic.sv @@
module gtg_cordic (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic signed [gtg_pkg::DIFF_W-1:0]  dx,
	input  logic signed [gtg_pkg::DIFF_W-1:0]  dy,
	output logic                               busy,
	output logic signed [gtg_pkg::ANG_W-1:0]   bearing
);

	localparam logic signed [gtg_pkg::CZ_W-1:0] PI_Z   = gtg_pkg::CZ_W'(gtg_pkg::PI_Q30);
	localparam logic signed [gtg_pkg::CZ_W-1:0] HALF_Z = gtg_pkg::CZ_W'(gtg_pkg::RND_HALF);

	logic signed [gtg_pkg::DIFF_W-1:0] ax, ay;
	logic signed [gtg_pkg::CX_W-1:0]   x_q, y_q, x0, y0, xs, ys;
	logic signed [gtg_pkg::CZ_W-1:0]   z_q, z0, at, zr;
	logic [gtg_pkg::ATAN_IDX_W-1:0]    step_q;
	logic                              busy_q, zero_q;
	logic signed [gtg_pkg::ANG_W-1:0]  bearing_q;

	always_comb begin
		// left half plane: turn the vector by pi first
		ax = dx[gtg_pkg::DIFF_W-1] ? -dx : dx;
		ay = dx[gtg_pkg::DIFF_W-1] ? -dy : dy;
		x0 = {{gtg_pkg::CX_PAD{ax[gtg_pkg::DIFF_W-1]}}, ax, {gtg_pkg::SCALE_SH{1'b0}}};
		y0 = {{gtg_pkg::CX_PAD{ay[gtg_pkg::DIFF_W-1]}}, ay, {gtg_pkg::SCALE_SH{1'b0}}};
		if (!dx[gtg_pkg::DIFF_W-1]) begin
			z0 = '0;
		end else if (dy[gtg_pkg::DIFF_W-1]) begin
			z0 = -PI_Z;
		end else begin
			z0 = PI_Z;
		end
		xs = x_q >>> step_q;
		ys = y_q >>> step_q;
		at = $signed({{(gtg_pkg::CZ_W - gtg_pkg::ATAN_W){1'b0}}, gtg_pkg::atan_q30(step_q)});
		zr = z_q + HALF_Z;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			if (step_q == gtg_pkg::ATAN_IDX_W'(gtg_pkg::CORDIC_STEPS)) begin
				busy_q <= 1'b0;
			end else begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= x0;
			y_q    <= y0;
			z_q    <= z0;
			zero_q <= (dx == '0) && (dy == '0);
		end else if (busy_q) begin
			if (step_q == gtg_pkg::ATAN_IDX_W'(gtg_pkg::CORDIC_STEPS)) begin
				// round q.30 to the output fraction
				bearing_q <= zero_q ? '0 : zr[gtg_pkg::RND_SH +: gtg_pkg::ANG_W];
			end else if (y_q[gtg_pkg::CX_W-1]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
		end
	end

	assign busy    = busy_q;
	assign bearing = bearing_q;

endmodule

@@ hdl/gtg_steer.sv @@
module gtg_steer (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic signed [gtg_pkg::ANG_W-1:0]   need,
	input  logic signed [gtg_pkg::ANG_W-1:0]   heading,
	input  gtg_pkg::cfg_t                      cfg,
	output logic                               busy,
	output logic signed [gtg_pkg::RATE_W-1:0]  rate
);

	localparam logic signed [gtg_pkg::ERR_W-1:0]  LIM_E  = gtg_pkg::ERR_W'(gtg_pkg::WRAP_LIM);
	localparam logic signed [gtg_pkg::ERR_W-1:0]  TWOPI_E = gtg_pkg::ERR_W'(gtg_pkg::TWO_PI_F);
	localparam logic signed [gtg_pkg::PROD_W-1:0] SAT_HI = gtg_pkg::PROD_W'(gtg_pkg::RATE_MAX);
	localparam logic signed [gtg_pkg::PROD_W-1:0] SAT_LO = gtg_pkg::PROD_W'(gtg_pkg::RATE_MIN);
	localparam logic [gtg_pkg::ST_CNT_W-1:0]      LAST   = gtg_pkg::ST_CNT_W'(gtg_pkg::GAIN_W + 1);

	logic signed [gtg_pkg::ERR_W-1:0]  h_ext, have_d, have_q, need_ext, err_q;
	logic signed [gtg_pkg::ANG_W-1:0]  need_q;
	logic signed [gtg_pkg::PROD_W-1:0] acc_q, acc_d, addend, mag;
	logic signed [gtg_pkg::RATE_W-1:0] rate_d, rate_q;
	logic [gtg_pkg::GAIN_W-1:0]        gsh_q;
	logic [gtg_pkg::ST_CNT_W-1:0]      cnt_q;
	logic                              busy_q, dead;

	always_comb begin
		// one wrap step covers the whole heading range
		h_ext = gtg_pkg::ERR_W'(heading);
		if (h_ext > LIM_E) begin
			have_d = h_ext - TWOPI_E;
		end else if (h_ext < -LIM_E) begin
			have_d = h_ext + TWOPI_E;
		end else begin
			have_d = h_ext;
		end
		need_ext = gtg_pkg::ERR_W'(need_q);
		addend   = gsh_q[gtg_pkg::GAIN_W-1] ? gtg_pkg::PROD_W'(err_q) : '0;
		acc_d    = (acc_q <<< 1) + addend;
		mag      = acc_q[gtg_pkg::PROD_W-1] ? -acc_q : acc_q;
		dead     = $unsigned(mag)
			< {{(gtg_pkg::PROD_W - gtg_pkg::DBAND_W){1'b0}}, cfg.deadband};
		if (dead) begin
			rate_d = '0;
		end else if (acc_q > SAT_HI) begin
			rate_d = gtg_pkg::RATE_W'(gtg_pkg::RATE_MAX);
		end else if (acc_q < SAT_LO) begin
			rate_d = gtg_pkg::RATE_W'(gtg_pkg::RATE_MIN);
		end else begin
			rate_d = acc_q[gtg_pkg::RATE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == LAST) begin
				busy_q <= 1'b0;
			end
		end
	end

	// phase 0: heading error, then one gain bit per cycle, then deadband and clamp
	always_ff @(posedge clk) begin
		if (start) begin
			have_q <= have_d;
			need_q <= need;
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				err_q <= need_ext - have_q;
				gsh_q <= cfg.gain;
				acc_q <= '0;
			end else if (cnt_q == LAST) begin
				rate_q <= rate_d;
			end else begin
				acc_q <= acc_d;
				gsh_q <= gsh_q << 1;
			end
		end
	end

	assign busy = busy_q;
	assign rate = rate_q;

endmodule

@@ hdl/go_to_goal_heading_controller_top.sv @@
// an own-pose transaction is taken while idle and gives no result; a target transaction
// gives its command after distance and bearing, plus steering when not reached;
// the next pose is taken the cycle after the command is registered; the cordic bearing
// loop runs one iteration per cycle, and the gain is applied bit-serially
// reset (arst_n low, asynchronous): idle, no command pending, poses zero,
// configuration registers at their default values
`include "go_to_goal_heading_controller_top_assert.svh"

module go_to_goal_heading_controller_top (
	input  logic                               clk,
	input  logic                               arst_n,
	gtg_pose_if.sink                           pose,
	gtg_cmd_if.source                          cmd,
	input  logic                               cfg_wr_en,
	input  logic [gtg_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [gtg_pkg::CFG_DATA_W-1:0]     cfg_data
);

	gtg_pkg::state_t state_q, state_d;
	gtg_pkg::cfg_t   cfg_q;

	// own pose
	logic [gtg_pkg::POS_W-1:0]        own_x_q, own_y_q;
	logic signed [gtg_pkg::ANG_W-1:0] own_heading_q;

	// position difference toward the new target
	logic signed [gtg_pkg::DIFF_W-1:0] dx, dy;

	// unit handshakes
	logic                              in_acc, calc_start, steer_start, out_load;
	logic                              sq_busy, cor_busy, steer_busy, units_idle;
	logic [gtg_pkg::DSQ_W-1:0]         dsq;
	logic                              reached_now, reached_q;
	logic signed [gtg_pkg::ANG_W-1:0]  bearing;
	logic signed [gtg_pkg::RATE_W-1:0] steer_rate;

	// output register
	logic                              out_valid_q;
	logic [gtg_pkg::SPEED_W-1:0]       out_speed_q;
	logic signed [gtg_pkg::RATE_W-1:0] out_rate_q;
	logic                              out_reached_q;

	// configuration writes, unknown indexes fall through
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.arrive_thr <= gtg_pkg::THR_W'(167772);
			cfg_q.fwd_speed  <= gtg_pkg::SPEED_W'(4096);
			cfg_q.gain       <= gtg_pkg::GAIN_W'(4);
			cfg_q.deadband   <= gtg_pkg::DBAND_W'(41);
		end else if (cfg_wr_en) begin
			case (gtg_pkg::cfg_idx_t'(cfg_index))
				gtg_pkg::CFG_ARRIVE:   cfg_q.arrive_thr <= cfg_data[gtg_pkg::THR_W-1:0];
				gtg_pkg::CFG_SPEED:    cfg_q.fwd_speed  <= cfg_data[gtg_pkg::SPEED_W-1:0];
				gtg_pkg::CFG_GAIN:     cfg_q.gain       <= cfg_data[gtg_pkg::GAIN_W-1:0];
				gtg_pkg::CFG_DEADBAND: cfg_q.deadband   <= cfg_data[gtg_pkg::DBAND_W-1:0];
				default: ;
			endcase
		end
	end

	// target minus own position, taken straight from the incoming transaction
	assign dx = $signed({1'b0, pose.pos_x}) - $signed({1'b0, own_x_q});
	assign dy = $signed({1'b0, pose.pos_y}) - $signed({1'b0, own_y_q});

	assign units_idle  = !sq_busy && !cor_busy;
	assign reached_now = dsq < {{(gtg_pkg::DSQ_W - gtg_pkg::THR_W){1'b0}}, cfg_q.arrive_thr};

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			gtg_pkg::ST_IDLE: begin
				if (pose.valid && pose.req_type != gtg_pkg::REQ_OWN) begin
					state_d = gtg_pkg::ST_CALC;
				end
			end
			gtg_pkg::ST_CALC: begin
				if (units_idle) begin
					state_d = reached_now ? gtg_pkg::ST_SEND : gtg_pkg::ST_TURN;
				end
			end
			gtg_pkg::ST_TURN: begin
				if (!steer_busy) begin
					state_d = gtg_pkg::ST_SEND;
				end
			end
			gtg_pkg::ST_SEND: begin
				if (!out_valid_q || cmd.ready) begin
					state_d = gtg_pkg::ST_IDLE;
				end
			end
			default: state_d = gtg_pkg::ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		pose.ready  = (state_q == gtg_pkg::ST_IDLE);
		in_acc      = pose.valid && pose.ready;
		calc_start  = in_acc && pose.req_type != gtg_pkg::REQ_OWN;
		steer_start = (state_q == gtg_pkg::ST_CALC) && units_idle && !reached_now;
		out_load    = (state_q == gtg_pkg::ST_SEND) && (!out_valid_q || cmd.ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gtg_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// own pose store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_x_q       <= '0;
			own_y_q       <= '0;
			own_heading_q <= '0;
		end else if (in_acc && pose.req_type == gtg_pkg::REQ_OWN) begin
			own_x_q       <= pose.pos_x;
			own_y_q       <= pose.pos_y;
			own_heading_q <= pose.heading;
		end
	end

	// arrival decision is kept for the command
	always_ff @(posedge clk) begin
		if (state_q == gtg_pkg::ST_CALC && units_idle) begin
			reached_q <= reached_now;
		end
	end

	// squared distance, one bit of each difference per cycle
	gtg_sqdist u_sqdist (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (calc_start),
		.dx     (dx),
		.dy     (dy),
		.busy   (sq_busy),
		.dsq    (dsq)
	);

	// bearing to the target, runs alongside the squared distance
	gtg_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (calc_start),
		.dx      (dx),
		.dy      (dy),
		.busy    (cor_busy),
		.bearing (bearing)
	);

	// heading wrap, gain, deadband and clamp
	gtg_steer u_steer (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (steer_start),
		.need    (bearing),
		.heading (own_heading_q),
		.cfg     (cfg_q),
		.busy    (steer_busy),
		.rate    (steer_rate)
	);

	// command register: holds a finished transaction while the sink stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (cmd.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_speed_q   <= reached_q ? '0 : cfg_q.fwd_speed;
			out_rate_q    <= reached_q ? '0 : steer_rate;
			out_reached_q <= reached_q;
		end
	end

	assign cmd.valid        = out_valid_q;
	assign cmd.linear_speed = out_speed_q;
	assign cmd.angular_rate = out_rate_q;
	assign cmd.reached      = out_reached_q;

	// a reached command carries zero speeds
	`GTG_CHECK(a_reached_stops, out_valid_q && out_reached_q, out_speed_q == '0 && out_rate_q == '0)
	// steering starts only once both front units are done
	`GTG_CHECK(a_steer_after_calc, steer_start, state_q == gtg_pkg::ST_CALC && units_idle)
	// the command register is never overwritten while pending
	`GTG_CHECK(a_no_overwrite, out_load, !out_valid_q || cmd.ready)
	// while steering the front units are quiet
	`GTG_CHECK(a_turn_units_idle, state_q == gtg_pkg::ST_TURN, units_idle)
	// an own-pose update gives no work
	`GTG_CHECK_NEXT(a_own_stays_idle, in_acc && pose.req_type == gtg_pkg::REQ_OWN, state_q == gtg_pkg::ST_IDLE && !sq_busy)

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps

module tb;
	import gtg_pkg::*;

	// clocking and run control
	localparam int     HALF_PERIOD     = 6;
	localparam int     RESET_CYCLES    = 7;
	localparam int     SETTLE_CYCLES   = 40;
	localparam int     HOLD_OFF_CYCLES = 300;        // long output stall to back the block up
	localparam longint RUN_LIMIT_NS    = 20_000_000; // far beyond the slowest legal run

	localparam logic   REQ_TARGET = ~REQ_OWN;

	// first index past the last register
	localparam cfg_idx_t CFG_PAST_END = cfg_idx_t'(CFG_DEADBAND + 1);

	// angle constants, rounded from q.30 to the output format
	localparam int     ROUND_SH      = 30 - FRAC_BITS;
	localparam longint ROUND_HALF    = longint'(1) << (ROUND_SH - 1);
	localparam longint HALF_TURN_Q30 = 64'sd3373259426;
	localparam longint HALF_TURN     = (HALF_TURN_Q30 + ROUND_HALF) >>> ROUND_SH;
	localparam longint FULL_TURN     = (2 * HALF_TURN_Q30 + ROUND_HALF) >>> ROUND_SH;
	localparam longint WRAP_EDGE     = HALF_TURN + ((longint'(1) << FRAC_BITS) + 50) / 100;
	localparam longint TURN_MAX      = (longint'(1) << (RATE_W - 1)) - 1;
	localparam longint TURN_MIN      = -(longint'(1) << (RATE_W - 1));

	typedef struct packed {
		logic                    req_type;
		logic [POS_W-1:0]        x;
		logic [POS_W-1:0]        y;
		logic signed [ANG_W-1:0] heading;
	} pose_t;

	typedef struct packed {
		logic [SPEED_W-1:0]       speed;
		logic signed [RATE_W-1:0] rate;
		logic                     reached;
	} drive_cmd_t;

	// one line of the directed sequence: either a register write or a pose transaction
	typedef struct {
		bit                    is_cfg;
		cfg_idx_t              idx;
		logic [CFG_DATA_W-1:0] data;
		pose_t                 pose;
		bit                    typed;
		drive_cmd_t            want;
	} stim_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_wr_en;
	cfg_idx_t              cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	gtg_pose_if pose_ch();
	gtg_cmd_if  cmd_ch();

	go_to_goal_heading_controller_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pose      (pose_ch),
		.cmd       (cmd_ch),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	// predictor copy of the stored poses and of the settings, reset values first
	logic [POS_W-1:0]        goal_x       = '0;
	logic [POS_W-1:0]        goal_y       = '0;
	logic [POS_W-1:0]        self_x       = '0;
	logic [POS_W-1:0]        self_y       = '0;
	logic signed [ANG_W-1:0] self_heading = '0;
	logic [THR_W-1:0]        arrive_thr   = 24'd167772;
	logic [SPEED_W-1:0]      speed_set    = 16'd4096;
	logic [GAIN_W-1:0]       gain_set     = 4'd4;
	logic [DBAND_W-1:0]      deadband_set = 12'd41;

	// atan(2^-i) in q.30 for the bearing iterations
	longint arctan_q30 [0:23] = '{
		843314856, 497837829, 263043836, 133525158, 67021686,
		33543515, 16775850, 8388437, 4194282, 2097149,
		1048575, 524287, 262143, 131071, 65535, 32767,
		16383, 8191, 4095, 2047, 1023, 511, 255, 127
	};

	drive_cmd_t cmds_due[$];      // commands predicted but not yet seen, oldest first
	stim_row_t  directed_rows[$];

	int poses_sent     = 0;
	int cmds_checked   = 0;
	int reached_seen   = 0;
	int saturated_seen = 0;
	int reg_writes     = 0;
	int failures       = 0;
	bit hold_off_req   = 1'b0;

	// vectoring cordic: angle of (dx, dy), rounded to the output format
	function automatic longint cordic_bearing(longint dx, longint dy);
		longint x, y, z, xs, ys;
		int     i;
		z = 0;
		if (dx == 0 && dy == 0)
			return 0;
		if (dx < 0) begin
			// fold the left half plane over by half a turn first
			x = -dx * 65536;
			y = -dy * 65536;
			z = (dy >= 0) ? HALF_TURN_Q30 : -HALF_TURN_Q30;
		end else begin
			x = dx * 65536;
			y = dy * 65536;
		end
		for (i = 0; i < CORDIC_STEPS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y < 0) begin
				x = x - ys;
				y = y + xs;
				z = z - arctan_q30[i];
			end else begin
				x = x + ys;
				y = y - xs;
				z = z + arctan_q30[i];
			end
		end
		return (z + ROUND_HALF) >>> ROUND_SH;
	endfunction

	// updates the stored poses; returns 1 with the command when a target causes one
	function automatic bit predict_command(pose_t p, output drive_cmd_t c);
		longint dx, dy, dsq, aim, have, rate, mag;
		c = '0;
		if (p.req_type == REQ_OWN) begin
			self_x       = p.x;
			self_y       = p.y;
			self_heading = p.heading;
			return 1'b0;
		end
		// target heading is not used at all
		goal_x = p.x;
		goal_y = p.y;
		dx  = longint'(goal_x) - longint'(self_x);
		dy  = longint'(goal_y) - longint'(self_y);
		dsq = dx * dx + dy * dy;
		if (dsq < longint'(arrive_thr)) begin
			c.reached = 1'b1;
			return 1'b1;
		end
		aim  = cordic_bearing(dx, dy);
		have = longint'(self_heading);
		while (have > WRAP_EDGE)
			have -= FULL_TURN;
		while (have < -WRAP_EDGE)
			have += FULL_TURN;
		// error is not rewrapped; deadband test comes before saturation
		rate = (aim - have) * longint'(gain_set);
		mag  = (rate < 0) ? -rate : rate;
		if (mag < longint'(deadband_set))
			rate = 0;
		if (rate > TURN_MAX)
			rate = TURN_MAX;
		if (rate < TURN_MIN)
			rate = TURN_MIN;
		c.speed   = speed_set;
		c.rate    = rate[RATE_W-1:0];
		c.reached = 1'b0;
		return 1'b1;
	endfunction

	// idle length for either side: mostly none or short, now and then long
	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 15);
		return $urandom_range(30, 80);
	endfunction

	// headings lean toward the wrap edges and the range limits
	function automatic logic signed [ANG_W-1:0] pick_heading();
		case ($urandom_range(0, 11))
			0:       return ANG_W'(WRAP_EDGE);
			1:       return ANG_W'(WRAP_EDGE + 1);
			2:       return ANG_W'(-WRAP_EDGE);
			3:       return ANG_W'(-WRAP_EDGE - 1);
			4:       return 16'sh7FFF;
			5:       return 16'sh8000;
			default: return ANG_W'($urandom);
		endcase
	endfunction

	// position a random power-of-two span around a base, wrapping at the range
	function automatic logic [POS_W-1:0] near_pos(logic [POS_W-1:0] base);
		int span;
		span = 1 << $urandom_range(0, 13);
		return base + POS_W'($urandom_range(0, 2 * span)) - POS_W'(span);
	endfunction

	function automatic void pose_row(logic kind, int x, int y, int h);
		stim_row_t r;
		r = '{idx: CFG_ARRIVE, default: '0};
		r.pose.req_type = kind;
		r.pose.x        = x[POS_W-1:0];
		r.pose.y        = y[POS_W-1:0];
		r.pose.heading  = h[ANG_W-1:0];
		directed_rows.push_back(r);
	endfunction

	// target transaction whose command is known without the predictor
	function automatic void checked_row(int x, int y, int h, int spd, longint rate, logic hit);
		stim_row_t r;
		r = '{idx: CFG_ARRIVE, default: '0};
		r.pose.req_type = REQ_TARGET;
		r.pose.x        = x[POS_W-1:0];
		r.pose.y        = y[POS_W-1:0];
		r.pose.heading  = h[ANG_W-1:0];
		r.typed         = 1'b1;
		r.want.speed    = spd[SPEED_W-1:0];
		r.want.rate     = rate[RATE_W-1:0];
		r.want.reached  = hit;
		directed_rows.push_back(r);
	endfunction

	function automatic void cfg_row(cfg_idx_t idx, int d);
		stim_row_t r;
		r = '{idx: CFG_ARRIVE, default: '0};
		r.is_cfg = 1'b1;
		r.idx    = idx;
		r.data   = CFG_DATA_W'(d);
		directed_rows.push_back(r);
	endfunction

	// offer one pose transaction, wait for it to be taken, then predict
	task automatic send_pose(pose_t p, bit eager, bit typed, drive_cmd_t typed_cmd);
		int         g;
		drive_cmd_t c;
		g = eager ? 0 : idle_gap();
		if (g > 0) begin
			pose_ch.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		pose_ch.valid    <= 1'b1;
		pose_ch.req_type <= p.req_type;
		pose_ch.pos_x    <= p.x;
		pose_ch.pos_y    <= p.y;
		pose_ch.heading  <= p.heading;
		do @(posedge clk); while (pose_ch.ready !== 1'b1);
		poses_sent++;
		if (predict_command(p, c))
			cmds_due.push_back(typed ? typed_cmd : c);
	endtask

	// stop offering, let every outstanding command arrive, then let the block settle
	task automatic drain_commands();
		pose_ch.valid <= 1'b0;
		while (cmds_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] d);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
		case (idx)
			CFG_ARRIVE:   arrive_thr   = d[THR_W-1:0];
			CFG_SPEED:    speed_set    = d[SPEED_W-1:0];
			CFG_GAIN:     gain_set     = d[GAIN_W-1:0];
			CFG_DEADBAND: deadband_set = d[DBAND_W-1:0];
			default: ;
		endcase
		reg_writes++;
	endtask

	task automatic apply_settings(logic [THR_W-1:0] thr, logic [SPEED_W-1:0] spd,
		logic [GAIN_W-1:0] gain, logic [DBAND_W-1:0] dband);
		drain_commands();
		write_reg(CFG_ARRIVE, CFG_DATA_W'(thr));
		write_reg(CFG_SPEED, CFG_DATA_W'(spd));
		write_reg(CFG_GAIN, CFG_DATA_W'(gain));
		write_reg(CFG_DEADBAND, CFG_DATA_W'(dband));
	endtask

	// random pose traffic: own poses wander, targets land near the own pose less often than at random
	task automatic run_random(int count, bit eager);
		pose_t      p;
		drive_cmd_t none;
		int         r;
		int         k;
		none = '0;
		for (k = 0; k < count; k++) begin
			r = $urandom_range(0, 99);
			p.req_type = (r < 30) ? REQ_OWN : REQ_TARGET;
			if (r < 15 || r >= 60) begin
				p.x = POS_W'($urandom);
				p.y = POS_W'($urandom);
			end else begin
				p.x = near_pos(self_x);
				p.y = near_pos(self_y);
			end
			p.heading = pick_heading();
			send_pose(p, eager, 1'b0, none);
		end
	endtask

	// command side: ready in random bursts, long stretches included,
	// plus one long hold-off on request to back the block up
	initial begin : cmd_sink
		int run_len;
		int gap;
		cmd_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_off_req) begin
				cmd_ch.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
			end
			run_len = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 200)
				: $urandom_range(1, 8);
			cmd_ch.ready <= 1'b1;
			repeat (run_len) @(posedge clk);
			gap = idle_gap();
			if (gap > 0) begin
				cmd_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	// every accepted command transaction is matched against the oldest prediction
	always @(posedge clk) begin : cmd_check
		drive_cmd_t want;
		if (arst_n === 1'b1 && cmd_ch.valid === 1'b1 && cmd_ch.ready === 1'b1) begin
			if (cmds_due.size() == 0) begin
				$error("drive command transaction with no command outstanding");
				failures++;
			end else begin
				want = cmds_due.pop_front();
				cmds_checked++;
				if (want.reached)
					reached_seen++;
				if (longint'(want.rate) == TURN_MAX || longint'(want.rate) == TURN_MIN)
					saturated_seen++;
				if (cmd_ch.linear_speed !== want.speed) begin
					$error("linear_speed: expected %0d, got %0d", want.speed,
						cmd_ch.linear_speed);
					failures++;
				end
				if (cmd_ch.angular_rate !== want.rate) begin
					$error("angular_rate: expected %0d, got %0d", want.rate,
						cmd_ch.angular_rate);
					failures++;
				end
				if (cmd_ch.reached !== want.reached) begin
					$error("reached: expected %0d, got %0d", want.reached, cmd_ch.reached);
					failures++;
				end
			end
		end
	end

	// hard stop in case the block hangs
	initial begin : watchdog
		#(RUN_LIMIT_NS);
		$display("run limit hit with %0d commands outstanding", cmds_due.size());
		$display("Test completed with failures");
		$finish;
	end

	initial begin : stimulus
		stim_row_t          row;
		logic [THR_W-1:0]   thr;
		logic [SPEED_W-1:0] spd;
		logic [GAIN_W-1:0]  gain;
		logic [DBAND_W-1:0] dband;
		int                 k;

		// every input known from time zero, reset held low before release
		arst_n           <= 1'b0;
		cfg_wr_en        <= 1'b0;
		cfg_index        <= CFG_ARRIVE;
		cfg_data         <= '0;
		pose_ch.valid    <= 1'b0;
		pose_ch.req_type <= REQ_TARGET;
		pose_ch.pos_x    <= '0;
		pose_ch.pos_y    <= '0;
		pose_ch.heading  <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: both poses at the origin, so the first target is reached
		checked_row(0, 0, 0, 0, 0, 1'b1);
		// just inside the default threshold, target heading at its maximum is ignored
		checked_row(400, 0, 32767, 0, 0, 1'b1);
		// outside it, target heading at its minimum
		pose_row(REQ_TARGET, 409, 409, -32768);
		// own pose at the right edge, heading at its maximum
		pose_row(REQ_OWN, 65535, 0, 32767);
		pose_row(REQ_TARGET, 0, 65535, 0);     // up and to the left
		pose_row(REQ_TARGET, 0, 0, 0);         // straight left, bearing of half a turn
		// own pose in the far corner, heading at its minimum
		pose_row(REQ_OWN, 65535, 65535, -32768);
		pose_row(REQ_TARGET, 0, 0, 16'h1234);  // down and to the left
		pose_row(REQ_TARGET, 65535, 0, 0);     // straight down
		checked_row(65535, 65535, 0, 0, 0, 1'b1);
		// own heading on either side of the wrap edge
		pose_row(REQ_OWN, 32768, 32768, int'(WRAP_EDGE));
		pose_row(REQ_TARGET, 40000, 32768, 0);
		pose_row(REQ_OWN, 32768, 32768, int'(WRAP_EDGE) + 1);
		pose_row(REQ_TARGET, 40000, 32768, 0);
		pose_row(REQ_OWN, 32768, 32768, -int'(WRAP_EDGE) - 1);
		pose_row(REQ_TARGET, 32768, 40000, 0);

		// zero threshold, full speed and gain, no deadband
		cfg_row(CFG_ARRIVE, 0);
		cfg_row(CFG_SPEED, 65535);
		cfg_row(CFG_GAIN, 15);
		cfg_row(CFG_DEADBAND, 0);
		// zero vector not counted as reached: bearing and rate are zero
		pose_row(REQ_OWN, 100, 100, 0);
		checked_row(100, 100, 32767, 65535, 0, 1'b0);
		// large heading errors saturate the turn rate both ways
		pose_row(REQ_OWN, 32768, 32768, 32767);
		checked_row(0, 0, 0, 65535, TURN_MIN, 1'b0);
		pose_row(REQ_OWN, 32768, 32768, -32768);
		checked_row(65535, 65535, 0, 65535, TURN_MAX, 1'b0);

		// widest deadband swallows an eighth-turn error at unit gain
		cfg_row(CFG_GAIN, 1);
		cfg_row(CFG_DEADBAND, 4095);
		pose_row(REQ_OWN, 32768, 32768, 0);
		checked_row(40000, 40000, 0, 65535, 0, 1'b0);
		pose_row(REQ_TARGET, 32768, 65535, 0);

		// largest threshold
		cfg_row(CFG_ARRIVE, 16777215);
		checked_row(36768, 32768, 0, 0, 0, 1'b1);
		// a write past the last register leaves the threshold alone
		cfg_row(CFG_PAST_END, 0);
		checked_row(36768, 32768, 0, 0, 0, 1'b1);

		while (directed_rows.size() != 0) begin
			row = directed_rows.pop_front();
			if (row.is_cfg) begin
				drain_commands();
				write_reg(row.idx, row.data);
			end else begin
				send_pose(row.pose, 1'b0, row.typed, row.want);
			end
		end

		// settings at the low and high extremes
		apply_settings(24'd0, 16'hFFFF, 4'd15, 12'd0);
		run_random(200, 1'b0);
		apply_settings(24'hFFFFFF, 16'd0, 4'd0, 12'hFFF);
		run_random(150, 1'b0);

		// back to the reset values; the command side holds off while poses keep coming
		apply_settings(24'd167772, 16'd4096, 4'd4, 12'd41);
		hold_off_req = 1'b1;
		run_random(80, 1'b1);
		run_random(140, 1'b0);

		// random settings, deadband mostly small so turn rates show through
		for (k = 0; k < 3; k++) begin
			thr   = THR_W'($urandom);
			spd   = SPEED_W'($urandom);
			gain  = GAIN_W'($urandom);
			dband = ($urandom_range(0, 3) == 0) ? DBAND_W'($urandom)
				: DBAND_W'($urandom_range(0, 300));
			apply_settings(thr, spd, gain, dband);
			run_random(220, (k == 1));
		end

		drain_commands();
		$display("covered %0d pose transactions under %0d register writes, %0d commands checked",
			poses_sent, reg_writes, cmds_checked);
		$display("of those %0d reached the goal and %0d sat at the turn rate limit",
			reached_seen, saturated_seen);
		if (failures == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
